@@ design/cpa_pkg.sv @@
// Shared types, codes and constants for the core placement allocator.
package cpa_pkg;

  localparam int MAX_CPUS_DEF    = 64;
  localparam int MAX_SOCKETS_DEF = 16;

  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 6;
  localparam int SOCK_W     = 4;
  localparam int ROUND_W    = 2;
  localparam int CNT_W      = 16;
  localparam int CPU_CNT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CNT_W-1:0] PARK_COUNT = 16'd10000;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD   = 2'd0,
    FN_SKIP   = 2'd1,
    FN_ALLOC  = 2'd2,
    FN_SHARED = 2'd3
  } func_t;

  typedef enum logic [ROUND_W-1:0] {
    RND_PREF  = 2'd0,
    RND_ANY   = 2'd1,
    RND_LEAST = 2'd2,
    RND_NONE  = 2'd3
  } round_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREF_SOCK  = 2'd0,
    CFG_SHARED_CPU = 2'd1,
    CFG_CPU_COUNT  = 2'd2
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch item, clear scan state
    logic issue;  // read one entry, step address
    logic fin;    // commit write, register result
  } cmd_t;

endpackage

@@ design/cpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cpa_ctrl.sv @@
// Sequencing state machine of the core placement allocator.
module cpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cpa_pkg::func_t func,
  input  logic          at_last,
  output cpa_pkg::cmd_t cmd,
  output logic          busy
);
  import cpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          // load and skip need no read
          if (func == FN_LOAD || func == FN_SKIP) begin
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (at_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_FIN;   // last read data lands here
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/cpa_dp.sv @@
// Datapath: config registers, count and socket memories, scan trackers, result.
module cpa_dp #(
  parameter int MAX_CPUS    = cpa_pkg::MAX_CPUS_DEF,
  parameter int MAX_SOCKETS = cpa_pkg::MAX_SOCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cpa_pkg::cmd_t                  cmd,
  output logic                           at_last,
  input  cpa_pkg::func_t                 func,
  input  logic [cpa_pkg::IDX_W-1:0]      cpu_index,
  input  logic [cpa_pkg::SOCK_W-1:0]     socket_id,
  input  logic                           cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic [cpa_pkg::IDX_W-1:0]      cpu,
  output logic [cpa_pkg::ROUND_W-1:0]    placement_round,
  output logic                           status
);
  import cpa_pkg::*;

  localparam int CW = $clog2(MAX_CPUS);
  localparam int NW = CW + 1;

  // config
  logic [SOCK_W-1:0]    pref_sock;
  logic [IDX_W-1:0]     shared_cpu;
  logic [CPU_CNT_W-1:0] cpu_count;

  // latched item
  func_t             f_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SOCK_W-1:0] sock_q;

  // scan
  logic [CW-1:0]    addr;
  logic             pend;
  logic [CW-1:0]    pend_idx;
  logic             pref_found;
  logic             any_found;
  logic [CW-1:0]    pref_idx;
  logic [CW-1:0]    any_idx;
  logic [CNT_W-1:0] min_cnt;
  logic [CW-1:0]    min_idx;

  logic [NW-1:0]    n_live;
  logic [CW-1:0]    last_idx;
  logic             shr;
  logic [CW-1:0]    raddr;
  logic             idle_en;

  // memories and their valid bits
  logic [MAX_CPUS-1:0] cnt_vld;
  logic [MAX_CPUS-1:0] sock_vld;
  logic                cnt_vld_q;
  logic                sock_vld_q;
  logic [CNT_W-1:0]    cnt_rd;
  logic [SOCK_W-1:0]   sock_rd;
  logic [CNT_W-1:0]    cur_cnt;
  logic [SOCK_W-1:0]   cur_sock;

  logic                cnt_we;
  logic [CW-1:0]       cnt_waddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic                sock_we;
  logic [CW-1:0]       sock_waddr;

  logic [CNT_W-1:0]    raised;
  logic [IDX_W-1:0]    res_cpu;
  round_t              res_round;
  logic                res_status;
  logic                in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      pref_sock  <= '0;
      shared_cpu <= '0;
      cpu_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PREF_SOCK:  pref_sock  <= cfg_data[SOCK_W-1:0];
        CFG_SHARED_CPU: shared_cpu <= cfg_data[IDX_W-1:0];
        CFG_CPU_COUNT:  cpu_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_live   = (int'(cpu_count) > MAX_CPUS) ? NW'(MAX_CPUS) : NW'(cpu_count);
  // no CPUs present still scans CPU 0 for the least-count fallback
  assign last_idx = (n_live == '0) ? '0 : CW'(n_live - NW'(1));
  assign shr      = (f_q == FN_SHARED);
  assign raddr    = shr ? CW'(shared_cpu) : addr;
  assign at_last  = shr || (addr == last_idx);
  assign idle_en  = (f_q == FN_ALLOC) && (n_live != '0);

  assign cur_cnt  = cnt_vld_q  ? cnt_rd  : '0;
  assign cur_sock = sock_vld_q ? sock_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_q    <= func;
      idx_q  <= cpu_index;
      sock_q <= socket_id;
    end
    if (cmd.issue) begin
      pend_idx <= raddr;
    end
    cnt_vld_q  <= cnt_vld[raddr];
    sock_vld_q <= sock_vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      pend       <= 1'b0;
      pref_found <= 1'b0;
      any_found  <= 1'b0;
      min_cnt    <= COUNT_MAX;
      min_idx    <= '0;
    end else begin
      pend <= cmd.issue;
      if (cmd.load) begin
        addr       <= '0;
        pref_found <= 1'b0;
        any_found  <= 1'b0;
        min_cnt    <= COUNT_MAX;
        min_idx    <= '0;
      end else begin
        if (cmd.issue) begin
          addr <= addr + CW'(1);
        end
        if (pend) begin
          if (idle_en && cur_cnt == '0 && cur_sock == pref_sock && !pref_found) begin
            pref_found <= 1'b1;
          end
          if (idle_en && cur_cnt == '0 && !any_found) begin
            any_found <= 1'b1;
          end
          // strict less-than keeps the first CPU holding the minimum
          if (cur_cnt < min_cnt) begin
            min_cnt <= cur_cnt;
            min_idx <= pend_idx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend && idle_en && cur_cnt == '0) begin
      if (cur_sock == pref_sock && !pref_found) begin
        pref_idx <= pend_idx;
      end
      if (!any_found) begin
        any_idx <= pend_idx;
      end
    end
  end

  assign raised = (min_cnt == COUNT_MAX) ? min_cnt : min_cnt + CNT_W'(1);

  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = '0;
    cnt_wdata  = '0;
    sock_we    = 1'b0;
    sock_waddr = CW'(idx_q);
    res_cpu    = idx_q;
    res_round  = RND_NONE;
    res_status = 1'b0;
    in_range   = 1'b0;
    case (f_q)
      FN_LOAD: begin
        in_range   = (int'(idx_q) < MAX_CPUS) && (int'(sock_q) < MAX_SOCKETS);
        sock_we    = cmd.fin && in_range;
        res_status = !in_range;
      end
      FN_SKIP: begin
        in_range   = (int'(idx_q) < int'(n_live));
        cnt_we     = cmd.fin && in_range;
        cnt_waddr  = CW'(idx_q);
        cnt_wdata  = PARK_COUNT;
        res_status = !in_range;
      end
      FN_SHARED: begin
        in_range   = (int'(shared_cpu) < MAX_CPUS);
        cnt_we     = cmd.fin && in_range;
        cnt_waddr  = CW'(shared_cpu);
        cnt_wdata  = raised;
        res_cpu    = shared_cpu;
        res_status = !in_range;
      end
      FN_ALLOC: begin
        cnt_we = cmd.fin;
        if (pref_found) begin
          cnt_waddr = pref_idx;
          cnt_wdata = CNT_W'(1);
          res_round = RND_PREF;
        end else if (any_found) begin
          cnt_waddr = any_idx;
          cnt_wdata = CNT_W'(1);
          res_round = RND_ANY;
        end else begin
          cnt_waddr = min_idx;
          cnt_wdata = raised;
          res_round = RND_LEAST;
        end
        res_cpu = IDX_W'(cnt_waddr);
      end
      default: begin
        res_status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld  <= '0;
      sock_vld <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      if (sock_we) begin
        sock_vld[sock_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      cpu             <= res_cpu;
      placement_round <= res_round;
      status          <= res_status;
    end
  end

  cpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_CPUS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  cpa_ram #(
    .WIDTH (SOCK_W),
    .DEPTH (MAX_CPUS)
  ) u_sock_ram (
    .clk   (clk),
    .we    (sock_we),
    .waddr (sock_waddr),
    .wdata (sock_q),
    .raddr (raddr),
    .rdata (sock_rd)
  );

  // no memory write while a scan is reading
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !cnt_we && !sock_we)
    else $error("memory written during scan");

  // an idle CPU on the preferred socket is also an idle CPU
  a_pref_implies_any: assert property (@(posedge clk) disable iff (rst)
    pref_found |-> any_found)
    else $error("preferred idle found without any idle");

  // allocation results, the only ones with a round other than none, are never ignored
  a_alloc_status: assert property (@(posedge clk) disable iff (rst)
    done && placement_round != RND_NONE |-> status == 1'b0)
    else $error("allocation reported as ignored");

endmodule

@@ design/core_placement_allocator_core.sv @@
// Top level of the core placement allocator: controller plus datapath.
// Load and skip go from accept through the finish state to the done strobe;
// shared and allocate pass a read scan and a wait state first. Allocate scans
// n = min(cpu_count, MAX_CPUS) entries, or 1 when that is 0, one read per cycle.
// The next item can be accepted in the cycle its predecessor's done is high.
// Results cannot be stalled. Synchronous reset clears the configuration
// registers and done and zeroes all counts and sockets at once through
// per-entry valid bits; no clearing pass.
module core_placement_allocator_core #(
  parameter int MAX_CPUS    = cpa_pkg::MAX_CPUS_DEF,
  parameter int MAX_SOCKETS = cpa_pkg::MAX_SOCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // item command
  input  logic                           start,
  output logic                           busy,
  input  logic [cpa_pkg::FUNC_W-1:0]     func,
  input  logic [cpa_pkg::IDX_W-1:0]      cpu_index,
  input  logic [cpa_pkg::SOCK_W-1:0]     socket_id,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0] cfg_data,
  // result, one-cycle strobe
  output logic                           done,
  output logic [cpa_pkg::IDX_W-1:0]      cpu,
  output logic [cpa_pkg::ROUND_W-1:0]    placement_round,
  output logic                           status
);
  import cpa_pkg::*;

  cmd_t  cmd;
  logic  at_last;
  logic  go;
  func_t func_e;

  // an item is taken only when the sequencer is idle
  assign go     = start && !busy;
  assign func_e = func_t'(func);

  cpa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (go),
    .func    (func_e),
    .at_last (at_last),
    .cmd     (cmd),
    .busy    (busy)
  );

  // datapath: scans the count memory once per allocate, tracking the first
  // idle preferred CPU, the first idle CPU and the first least-count CPU
  cpa_dp #(
    .MAX_CPUS    (MAX_CPUS),
    .MAX_SOCKETS (MAX_SOCKETS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .at_last         (at_last),
    .func            (func_e),
    .cpu_index       (cpu_index),
    .socket_id       (socket_id),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .cpu             (cpu),
    .placement_round (placement_round),
    .status          (status)
  );

endmodule
